/* hdl/binary_grid_island_counter_assert.svh */
// Assertion macros used by the island counter RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BINARY_GRID_ISLAND_COUNTER_ASSERT_SVH
`define BINARY_GRID_ISLAND_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define BGIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BGIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bgic_pkg.sv */
package bgic_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int POS_W  = $clog2(CELL_COUNT + 1);
    localparam int QUE_W  = ROW_W + COL_W;

    localparam int DIM_W     = 7;
    localparam int COUNT_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // Grid cell codes: bit 0 land, bit 1 visited
    localparam logic [1:0] CELL_WATER = 2'b00;
    localparam logic [1:0] CELL_LAND  = 2'b01;
    localparam logic [1:0] CELL_SEEN  = 2'b11;

    // Neighbor order: up, down, left, right
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic land_bit;
        logic last_cell;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] island_count;
        logic               overflow;
    } out_word_t;

endpackage

/* hdl/bgic_ram.sv */
module bgic_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/binary_grid_island_counter.sv */
// Counts the 4-connected land regions of a binary grid of up to 64 by 64 cells.
// Cells load one word per cycle in raster order while in_stall is low; cells
// past rows times columns are dropped and flagged. After the word marked
// last_cell the block scans all 4096 grid entries and flood-fills each new
// region breadth-first, popping each queued cell and checking its in-range
// neighbors, all through a grid RAM and a frontier-queue RAM that each have
// one read and one write port. The scan clears the grid behind itself, so the
// next frame loads right away. After reset a clearing pass over all 4096
// entries runs before the first word is taken. Configuration is taken at any
// time with cfg_ready held high.
`include "binary_grid_island_counter_assert.svh"

module binary_grid_island_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bgic_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bgic_pkg::out_word_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bgic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgic_pkg::DIM_W-1:0]    cfg_data
);

    import bgic_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_LOAD     = 4'd1;
    localparam logic [3:0] ST_SCAN_RD  = 4'd2;
    localparam logic [3:0] ST_SCAN_CHK = 4'd3;
    localparam logic [3:0] ST_POP      = 4'd4;
    localparam logic [3:0] ST_CENTER   = 4'd5;
    localparam logic [3:0] ST_NREQ     = 4'd6;
    localparam logic [3:0] ST_NCHK     = 4'd7;

    localparam logic [POS_W-1:0] POS_END  = POS_W'(CELL_COUNT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CELL_COUNT - 1);

    logic [3:0]         state_reg, state_next;
    logic [DIM_W-1:0]   grid_rows_reg, grid_cols_reg;
    logic [POS_W-1:0]   sp_reg, sp_next;
    logic [ROW_W-1:0]   sr_reg, sr_next;
    logic [COL_W-1:0]   sc_reg, sc_next;
    logic [POS_W-1:0]   lp_reg, lp_next;
    logic               ovf_reg, ovf_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [POS_W-1:0]   head_reg, head_next;
    logic [POS_W-1:0]   tail_reg, tail_next;
    logic [1:0]         dir_reg, dir_next;
    logic               out_valid_reg, out_valid_next;

    logic [RDIM_W-1:0]  rows_f_reg, rows_f_next;
    logic [CDIM_W-1:0]  cols_f_reg, cols_f_next;
    logic [POS_W-1:0]   area_f_reg, area_f_next;
    logic [ROW_W-1:0]   cur_r_reg, cur_r_next;
    logic [COL_W-1:0]   cur_c_reg, cur_c_next;
    logic [ADDR_W-1:0]  cur_p_reg, cur_p_next;
    logic [ROW_W-1:0]   nr_reg, nr_next;
    logic [COL_W-1:0]   nc_reg, nc_next;
    logic [ADDR_W-1:0]  naddr_reg, naddr_next;
    out_word_t          out_word_reg, out_word_next;

    logic [RDIM_W-1:0]  rows_eff;
    logic [CDIM_W-1:0]  cols_eff;
    logic [POS_W-1:0]   area_eff;

    logic               grid_we;
    logic [ADDR_W-1:0]  grid_waddr, grid_raddr;
    logic [1:0]         grid_wdata, grid_rdata;
    logic               q_we;
    logic [ADDR_W-1:0]  q_waddr, q_raddr;
    logic [QUE_W-1:0]   q_wdata, q_rdata;

    logic               in_take;
    logic               out_free;
    logic               nb_ok;
    logic [ADDR_W-1:0]  nb_addr;
    logic [ROW_W-1:0]   nb_r;
    logic [COL_W-1:0]   nb_c;
    logic               sc_wrap;

    bgic_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    bgic_ram #(.WIDTH(QUE_W), .DEPTH(CELL_COUNT)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Clamp the dimensions: zero reads as one, large values saturate.
    always_comb
    begin
        if (grid_rows_reg == '0)
            rows_eff = RDIM_W'(1);
        else if (32'(grid_rows_reg) > MAX_ROWS)
            rows_eff = RDIM_W'(MAX_ROWS);
        else
            rows_eff = RDIM_W'(grid_rows_reg);
        if (grid_cols_reg == '0)
            cols_eff = CDIM_W'(1);
        else if (32'(grid_cols_reg) > MAX_COLS)
            cols_eff = CDIM_W'(MAX_COLS);
        else
            cols_eff = CDIM_W'(grid_cols_reg);
    end

    assign area_eff = POS_W'(rows_eff) * POS_W'(cols_eff);
    assign sc_wrap  = (CDIM_W'(sc_reg) + CDIM_W'(1)) == cols_f_reg;

    // Neighbor of the current cell in the current direction.
    always_comb
    begin
        nb_ok   = 1'b0;
        nb_addr = cur_p_reg;
        nb_r    = cur_r_reg;
        nb_c    = cur_c_reg;
        unique case (dir_reg)
            DIR_UP:
            begin
                nb_ok   = (cur_r_reg != '0);
                nb_addr = cur_p_reg - ADDR_W'(cols_f_reg);
                nb_r    = cur_r_reg - ROW_W'(1);
            end
            DIR_DOWN:
            begin
                nb_ok   = (RDIM_W'(cur_r_reg) + RDIM_W'(1)) < rows_f_reg;
                nb_addr = cur_p_reg + ADDR_W'(cols_f_reg);
                nb_r    = cur_r_reg + ROW_W'(1);
            end
            DIR_LEFT:
            begin
                nb_ok   = (cur_c_reg != '0);
                nb_addr = cur_p_reg - ADDR_W'(1);
                nb_c    = cur_c_reg - COL_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok   = (CDIM_W'(cur_c_reg) + CDIM_W'(1)) < cols_f_reg;
                nb_addr = cur_p_reg + ADDR_W'(1);
                nb_c    = cur_c_reg + COL_W'(1);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        lp_next        = lp_reg;
        ovf_next       = ovf_reg;
        total_next     = total_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg;
        rows_f_next    = rows_f_reg;
        cols_f_next    = cols_f_reg;
        area_f_next    = area_f_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        cur_p_next     = cur_p_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        naddr_next     = naddr_reg;
        out_word_next  = out_word_reg;

        grid_we    = 1'b0;
        grid_waddr = sp_reg[ADDR_W-1:0];
        grid_wdata = CELL_WATER;
        grid_raddr = sp_reg[ADDR_W-1:0];
        q_we       = 1'b0;
        q_waddr    = tail_reg[ADDR_W-1:0];
        q_wdata    = {sr_reg, sc_reg};
        q_raddr    = head_reg[ADDR_W-1:0];

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                grid_we = 1'b1;
                if (sp_reg == POS_LAST)
                begin
                    sp_next    = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    sp_next = sp_reg + POS_W'(1);
                end
            end
            ST_LOAD:
            begin
                if (in_take)
                begin
                    if (lp_reg < area_eff)
                    begin
                        grid_we    = 1'b1;
                        grid_waddr = lp_reg[ADDR_W-1:0];
                        grid_wdata = in_word.land_bit ? CELL_LAND : CELL_WATER;
                        lp_next    = lp_reg + POS_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_word.last_cell)
                    begin
                        rows_f_next = rows_eff;
                        cols_f_next = cols_eff;
                        area_f_next = area_eff;
                        sp_next     = '0;
                        sr_next     = '0;
                        sc_next     = '0;
                        total_next  = '0;
                        state_next  = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (sp_reg == POS_END)
                begin
                    // Hold the finished count until the output register frees.
                    if (out_free)
                    begin
                        out_valid_next             = 1'b1;
                        out_word_next.island_count = total_reg;
                        out_word_next.overflow     = ovf_reg;
                        lp_next                    = '0;
                        ovf_next                   = 1'b0;
                        sp_next                    = '0;
                        state_next                 = ST_LOAD;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                grid_we = 1'b1;
                if (sp_reg < area_f_reg && grid_rdata == CELL_LAND)
                begin
                    // Seed a new region with this cell.
                    grid_wdata = CELL_SEEN;
                    q_we       = 1'b1;
                    q_waddr    = '0;
                    head_next  = '0;
                    tail_next  = POS_W'(1);
                    state_next = ST_POP;
                end
                else
                begin
                    sp_next    = sp_reg + POS_W'(1);
                    sc_next    = sc_wrap ? '0 : sc_reg + COL_W'(1);
                    sr_next    = sc_wrap ? sr_reg + ROW_W'(1) : sr_reg;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    // Region done: count it, clear the seed cell, advance the scan.
                    if (total_reg != COUNT_MAX)
                        total_next = total_reg + COUNT_W'(1);
                    grid_we    = 1'b1;
                    sp_next    = sp_reg + POS_W'(1);
                    sc_next    = sc_wrap ? '0 : sc_reg + COL_W'(1);
                    sr_next    = sc_wrap ? sr_reg + ROW_W'(1) : sr_reg;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    head_next  = head_reg + POS_W'(1);
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                cur_r_next = q_rdata[QUE_W-1:COL_W];
                cur_c_next = q_rdata[COL_W-1:0];
                cur_p_next = ADDR_W'(q_rdata[QUE_W-1:COL_W]) * ADDR_W'(cols_f_reg)
                           + ADDR_W'(q_rdata[COL_W-1:0]);
                dir_next   = DIR_UP;
                state_next = ST_NREQ;
            end
            ST_NREQ:
            begin
                grid_raddr = nb_addr;
                if (nb_ok)
                begin
                    nr_next    = nb_r;
                    nc_next    = nb_c;
                    naddr_next = nb_addr;
                    state_next = ST_NCHK;
                end
                else if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            ST_NCHK:
            begin
                if (grid_rdata == CELL_LAND)
                begin
                    grid_we    = 1'b1;
                    grid_waddr = naddr_reg;
                    grid_wdata = CELL_SEEN;
                    q_we       = 1'b1;
                    q_wdata    = {nr_reg, nc_reg};
                    tail_next  = tail_reg + POS_W'(1);
                end
                if (dir_reg == DIR_RIGHT)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NREQ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            grid_rows_reg <= DIM_RESET;
            grid_cols_reg <= DIM_RESET;
            sp_reg        <= '0;
            sr_reg        <= '0;
            sc_reg        <= '0;
            lp_reg        <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            dir_reg       <= DIR_UP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            sr_reg        <= sr_next;
            sc_reg        <= sc_next;
            lp_reg        <= lp_next;
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                    default:       grid_rows_reg <= grid_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rows_f_reg   <= rows_f_next;
        cols_f_reg   <= cols_f_next;
        area_f_reg   <= area_f_next;
        cur_r_reg    <= cur_r_next;
        cur_c_reg    <= cur_c_next;
        cur_p_reg    <= cur_p_next;
        nr_reg       <= nr_next;
        nc_reg       <= nc_next;
        naddr_reg    <= naddr_next;
        out_word_reg <= out_word_next;
    end

    `BGIC_ASSERT_NOW(a_queue_order, state_reg == ST_POP, head_reg <= tail_reg, "queue head passed tail")
    `BGIC_ASSERT_NOW(a_scan_bound, 1'b1, sp_reg <= POS_END, "scan pointer out of range")
    `BGIC_ASSERT_NEXT(a_last_starts_scan, in_take && in_word.last_cell, state_reg == ST_SCAN_RD, "last word did not start the scan")
    `BGIC_ASSERT_NOW(a_mark_enqueues, grid_we && grid_wdata == CELL_SEEN, q_we, "cell marked visited without enqueue")

endmodule
